/* hdl/pcfe_pkg.sv */
// Shared types, codes and constants for the playback clock fade envelope unit.
`default_nettype none

package pcfe_pkg;

    // Input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FADE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANIM_DUR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_LEN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_LEN = 3'd6;

    // Fixed-point constants
    localparam logic [15:0] ONE_Q15       = 16'd32768;
    localparam logic [15:0] SPEED_RESET   = 16'd256;

    // Divider step counts: full word for the wrap, 16 quotient bits for a fade
    localparam int MOD_STEPS = 32;
    localparam int W_STEPS   = 16;
    localparam int CNT_W     = $clog2(MOD_STEPS);

    typedef struct packed {
        logic [1:0]  opcode;
        logic [30:0] delta;
    } item_t;

    typedef struct packed {
        logic               playing;
        logic signed [31:0] play_time;
        logic [15:0]        weight;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_ADD,
        ST_DIV,
        ST_MOD_FIX,
        ST_W_INIT,
        ST_W_OUT,
        ST_W_LOAD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DK_MOD,
        DK_FADE_IN,
        DK_FADE_OUT
    } div_kind_t;

endpackage

`default_nettype wire

/* hdl/playback_clock_fade_envelope_unit.sv */
// Playback clock with fade envelope: sequencer around one multiplier and one divider step.
// A fade-out item goes straight to the output state; a start runs the fade weight divisions
// that apply; a tick may also run the wrap remainder first (32 divider steps, 16 per fade fraction).
// Throughput: one item at a time; item_ready is high only while the sequencer idles,
// so a new item waits until the last one has passed the output state, which waits for a free slot.
// Reset (rst_n low, asynchronous): state idle, playback finished, time and weight zero,
// registers at their reset values (speed 1.0, base weight 1.0).
`default_nettype none

module playback_clock_fade_envelope_unit
    import pcfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic signed [41:0] SUM_MAX = 42'sd2147483647;
    localparam logic signed [41:0] SUM_MIN = -42'sd2147483648;

    // Configuration registers
    logic [30:0]        start_time_reg;
    logic signed [15:0] speed_reg;
    logic [30:0]        dur_reg;
    logic               loop_reg;
    logic [15:0]        base_w_reg;
    logic [30:0]        fin_len_reg;
    logic [30:0]        fout_len_reg;

    // Playback state
    state_t             state_reg, state_next;
    logic signed [31:0] time_reg, time_next;
    logic [30:0]        fil_reg, fil_next;
    logic [30:0]        fol_reg, fol_next;
    logic               fading_reg, fading_next;
    logic               finished_reg, finished_next;
    logic [15:0]        weight_reg, weight_next;

    // Work registers
    logic [30:0]        delta_reg, delta_next;
    logic [15:0]        w_reg, w_next;
    logic signed [48:0] prod_reg, prod_next;
    logic [30:0]        rem_reg, rem_next;
    logic [31:0]        shf_reg, shf_next;
    logic [30:0]        div_reg, div_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    div_kind_t          kind_reg, kind_next;
    logic               mod_neg_reg, mod_neg_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;

    // Shared multiplier
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;

    // Datapath terms
    logic signed [40:0] p_step;
    logic signed [41:0] sum;
    logic signed [31:0] t_sat;
    logic signed [31:0] dur_s;
    logic               t_gt_dur, t_ge_dur, t_neg, dur_zero;
    logic               fade_end;
    logic [15:0]        w0;
    logic               fil_zero, fil_full, fout_apply;
    logic [31:0]        trial;
    logic               ge;
    logic [31:0]        diff;
    logic [30:0]        rem_step;
    logic [31:0]        shf_step;
    logic               div_done;
    logic               slot_free;

    assign item_ready   = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign mul_p = mul_a * mul_b;

    // Position step and saturated sum
    assign p_step   = prod_reg[48:8];
    assign sum      = $signed({{10{time_reg[31]}}, time_reg}) + $signed({p_step[40], p_step});
    assign t_sat    = (sum > SUM_MAX) ? 32'sh7FFF_FFFF :
                      (sum < SUM_MIN) ? 32'sh8000_0000 : sum[31:0];
    assign dur_s    = $signed({1'b0, dur_reg});
    assign t_gt_dur = (t_sat > dur_s);
    assign t_ge_dur = (t_sat >= dur_s);
    assign t_neg    = t_sat[31];
    assign dur_zero = (dur_reg == 31'd0);

    // Fade countdown checks
    assign fade_end   = fading_reg && (fol_reg != 31'd0) && (delta_reg > fol_reg);
    assign w0         = (base_w_reg > ONE_Q15) ? ONE_Q15 : base_w_reg;
    assign fil_zero   = (fil_reg == 31'd0);
    assign fil_full   = (fil_reg >= fin_len_reg);
    assign fout_apply = (fol_reg != 31'd0) && (fol_reg < fout_len_reg);

    // Restoring divider step
    assign trial    = {rem_reg, shf_reg[31]};
    assign ge       = (trial >= {1'b0, div_reg});
    assign diff     = trial - {1'b0, div_reg};
    assign rem_step = ge ? diff[30:0] : trial[30:0];
    assign shf_step = {shf_reg[30:0], ge};
    assign div_done = (cnt_reg == '0);

    assign slot_free = !result_valid_reg || result_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.opcode)
                        OP_START: state_next = ST_W_INIT;
                        OP_FADE:  state_next = ST_OUT;
                        OP_TICK:  state_next = finished_reg ? ST_OUT : ST_TICK;
                        default:  state_next = ST_OUT;
                    endcase
                end
            end
            ST_TICK:
                state_next = fade_end ? ST_OUT : ST_ADD;
            ST_ADD:
            begin
                if (loop_reg)
                    state_next = (!dur_zero && (t_gt_dur || t_neg)) ? ST_DIV : ST_W_INIT;
                else
                    state_next = t_ge_dur ? ST_OUT : ST_W_INIT;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    unique case (kind_reg)
                        DK_MOD:      state_next = ST_MOD_FIX;
                        DK_FADE_IN:  state_next = ST_W_OUT;
                        DK_FADE_OUT: state_next = ST_OUT;
                        default:     state_next = ST_OUT;
                    endcase
                end
            end
            ST_MOD_FIX:
                state_next = ST_W_INIT;
            ST_W_INIT:
                state_next = (fil_zero || fil_full) ? ST_W_OUT : ST_W_LOAD;
            ST_W_OUT:
                state_next = fout_apply ? ST_W_LOAD : ST_OUT;
            ST_W_LOAD:
                state_next = ST_DIV;
            ST_OUT:
                state_next = slot_free ? ST_IDLE : ST_OUT;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        time_next         = time_reg;
        fil_next          = fil_reg;
        fol_next          = fol_reg;
        fading_next       = fading_reg;
        finished_next     = finished_reg;
        weight_next       = weight_reg;
        delta_next        = delta_reg;
        w_next            = w_reg;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        shf_next          = shf_reg;
        div_next          = div_reg;
        cnt_next          = cnt_reg;
        kind_next         = kind_reg;
        mod_neg_next      = mod_neg_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        mul_a             = $signed({1'b0, delta_reg});
        mul_b             = $signed({speed_reg[15], speed_reg});

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.opcode)
                        OP_START:
                        begin
                            time_next     = $signed({1'b0, start_time_reg});
                            fil_next      = fin_len_reg;
                            fol_next      = 31'd0;
                            fading_next   = 1'b0;
                            finished_next = 1'b0;
                        end
                        OP_FADE:
                        begin
                            fol_next    = fout_len_reg;
                            fading_next = 1'b1;
                        end
                        OP_TICK:
                            delta_next = item.delta;
                        default:
                            delta_next = delta_reg;
                    endcase
                end
            end
            ST_TICK:
            begin
                // Count the fades down and form delta * speed
                if (!fil_zero)
                    fil_next = (delta_reg >= fil_reg) ? 31'd0 : fil_reg - delta_reg;
                if (fade_end)
                    finished_next = 1'b1;
                else if (fading_reg && (fol_reg != 31'd0))
                    fol_next = fol_reg - delta_reg;
                prod_next = mul_p;
            end
            ST_ADD:
            begin
                if (loop_reg)
                begin
                    rem_next  = 31'd0;
                    div_next  = dur_reg;
                    cnt_next  = CNT_W'(MOD_STEPS - 1);
                    kind_next = DK_MOD;
                    if (dur_zero)
                        time_next = 32'sd0;
                    else if (t_gt_dur)
                    begin
                        shf_next     = t_sat - 32'sd1;
                        mod_neg_next = 1'b0;
                    end
                    else if (t_neg)
                    begin
                        shf_next     = -t_sat;
                        mod_neg_next = 1'b1;
                    end
                    else
                        time_next = t_sat;
                end
                else
                begin
                    time_next = t_sat;
                    if (t_ge_dur)
                        finished_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                shf_next = shf_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (div_done && (kind_reg == DK_FADE_IN))
                    w_next = shf_step[15:0];
                if (div_done && (kind_reg == DK_FADE_OUT))
                    weight_next = shf_step[15:0];
            end
            ST_MOD_FIX:
            begin
                // Map the remainder back into the loop range
                if (mod_neg_reg)
                    time_next = (rem_reg == 31'd0) ? 32'sd0 :
                                $signed({1'b0, dur_reg - rem_reg});
                else
                    time_next = $signed({1'b0, rem_reg} + 32'd1);
            end
            ST_W_INIT:
            begin
                kind_next = DK_FADE_IN;
                if (fil_zero)
                    w_next = w0;
                else if (fil_full)
                    w_next = 16'd0;
                else
                begin
                    mul_a     = $signed({1'b0, fin_len_reg - fil_reg});
                    mul_b     = $signed({1'b0, w0});
                    prod_next = mul_p;
                end
            end
            ST_W_OUT:
            begin
                kind_next = DK_FADE_OUT;
                if (fout_apply)
                begin
                    mul_a     = $signed({1'b0, fol_reg});
                    mul_b     = $signed({1'b0, w_reg});
                    prod_next = mul_p;
                end
                else
                    weight_next = w_reg;
            end
            ST_W_LOAD:
            begin
                // Product high part is already below the divisor
                rem_next = prod_reg[46:16];
                shf_next = {prod_reg[15:0], 16'h0000};
                div_next = (kind_reg == DK_FADE_IN) ? fin_len_reg : fout_len_reg;
                cnt_next = CNT_W'(W_STEPS - 1);
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    result_valid_next     = 1'b1;
                    result_next.playing   = !finished_reg;
                    result_next.play_time = time_reg;
                    result_next.weight    = weight_reg;
                end
            end
            default:
                result_next = result_reg;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            time_reg         <= 32'sd0;
            fil_reg          <= 31'd0;
            fol_reg          <= 31'd0;
            fading_reg       <= 1'b0;
            finished_reg     <= 1'b1;
            weight_reg       <= 16'd0;
            kind_reg         <= DK_MOD;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            time_reg         <= time_next;
            fil_reg          <= fil_next;
            fol_reg          <= fol_next;
            fading_reg       <= fading_next;
            finished_reg     <= finished_next;
            weight_reg       <= weight_next;
            kind_reg         <= kind_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload work registers
    always_ff @(posedge clk)
    begin
        delta_reg   <= delta_next;
        w_reg       <= w_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        shf_reg     <= shf_next;
        div_reg     <= div_next;
        mod_neg_reg <= mod_neg_next;
        result_reg  <= result_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= 31'd0;
            speed_reg      <= $signed(SPEED_RESET);
            dur_reg        <= 31'd0;
            loop_reg       <= 1'b0;
            base_w_reg     <= ONE_Q15;
            fin_len_reg    <= 31'd0;
            fout_len_reg   <= 31'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_TIME:   start_time_reg <= cfg_data[30:0];
                REG_SPEED:        speed_reg      <= $signed(cfg_data[15:0]);
                REG_ANIM_DUR:     dur_reg        <= cfg_data[30:0];
                REG_LOOP_ENABLE:  loop_reg       <= cfg_data[0];
                REG_BASE_WEIGHT:  base_w_reg     <= cfg_data[15:0];
                REG_FADE_IN_LEN:  fin_len_reg    <= cfg_data[30:0];
                REG_FADE_OUT_LEN: fout_len_reg   <= cfg_data[30:0];
                default:          loop_reg       <= loop_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/pcfe_checker.sv */
// Port-level assertions for the playback clock fade envelope unit, with its bind.
`default_nettype none

module pcfe_checker
    import pcfe_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire item_t   item,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    // Drop ready for the cycle after a transfer is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item_ready high right after an input transfer");

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // A fade-out item into an empty output slot goes through the output state to a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.opcode == OP_FADE) && !result_valid
        |-> ##2 result_valid)
        else $error("fade-out result missing");

    // Keep the reported weight within unity
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.weight <= ONE_Q15))
        else $error("weight above 1.0");

endmodule

bind playback_clock_fade_envelope_unit pcfe_checker u_pcfe_checker (.*);

`default_nettype wire

/* tb/sv/envelope_checker.sv */
// Checker for the playback clock fade envelope unit: predicts every status and compares it.
`timescale 1ns / 1ps

module envelope_checker
    import pcfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    backlog
);

    localparam longint TIME_MAX = 64'sd2147483647;
    localparam longint TIME_MIN = -64'sd2147483648;
    localparam int     REPORT_LIMIT = 10;

    // Register copies as the block sees them
    logic [30:0] start_time_r;
    logic [15:0] speed_r;
    logic [30:0] anim_dur_r;
    logic        loop_r;
    logic [15:0] base_weight_r;
    logic [30:0] fade_in_len_r;
    logic [30:0] fade_out_len_r;

    // Playback state
    logic [31:0] time_now;
    logic [31:0] fade_in_left;
    logic [31:0] fade_out_left;
    logic [15:0] weight_now;
    logic        fading_out;
    logic        finished;

    result_t status_due[$];
    int      fail_count;

    assign mismatches = fail_count;

    // Base weight scaled by the fade-in fraction done and the fade-out fraction left
    function automatic logic [15:0] blend_weight();
        longint unsigned w;
        w = base_weight_r;
        if (w > ONE_Q15)
            w = ONE_Q15;
        if (fade_in_left != 0)
        begin
            if (fade_in_left >= fade_in_len_r)
                w = 0;
            else
                w = w * (fade_in_len_r - fade_in_left) / fade_in_len_r;
        end
        if (fade_out_left != 0 && fade_out_left < fade_out_len_r)
            w = w * fade_out_left / fade_out_len_r;
        return w[15:0];
    endfunction

    // Count the fades down, then advance, saturate and wrap or end the position
    task automatic advance_clock(input logic [30:0] delta);
        longint step;
        longint pos;
        longint span;
        longint rem;
        if (fade_in_left != 0)
            fade_in_left = (delta >= fade_in_left) ? 32'd0 : fade_in_left - delta;
        if (fading_out && fade_out_left != 0 && delta > fade_out_left)
            finished = 1'b1;
        else
        begin
            if (fading_out && fade_out_left != 0)
                fade_out_left = fade_out_left - delta;
            step = (longint'(delta) * longint'($signed(speed_r))) >>> 8;
            pos  = longint'($signed(time_now)) + step;
            if (pos > TIME_MAX)
                pos = TIME_MAX;
            if (pos < TIME_MIN)
                pos = TIME_MIN;
            span = longint'(anim_dur_r);
            if (loop_r)
            begin
                if (span == 0)
                    pos = 0;
                else if (pos > span)
                    pos = ((pos - 1) % span) + 1;
                else if (pos < 0)
                begin
                    rem = (-pos) % span;
                    pos = (rem == 0) ? 0 : span - rem;
                end
                time_now   = pos[31:0];
                weight_now = blend_weight();
            end
            else
            begin
                time_now = pos[31:0];
                if (pos >= span)
                    finished = 1'b1;
                else
                    weight_now = blend_weight();
            end
        end
    endtask

    // Apply one accepted item and queue the status it reports
    task automatic predict_status(input item_t it);
        result_t due;
        case (it.opcode)
            OP_START:
            begin
                time_now      = {1'b0, start_time_r};
                fade_in_left  = {1'b0, fade_in_len_r};
                fade_out_left = 32'd0;
                fading_out    = 1'b0;
                finished      = 1'b0;
                weight_now    = blend_weight();
            end
            OP_FADE:
            begin
                fade_out_left = {1'b0, fade_out_len_r};
                fading_out    = 1'b1;
            end
            OP_TICK:
            begin
                if (!finished)
                    advance_clock(it.delta);
            end
            default: ;
        endcase
        due.playing   = !finished;
        due.play_time = time_now;
        due.weight    = weight_now;
        status_due.push_back(due);
    endtask

    task automatic store_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_START_TIME:   start_time_r   = data[30:0];
            REG_SPEED:        speed_r        = data[15:0];
            REG_ANIM_DUR:     anim_dur_r     = data[30:0];
            REG_LOOP_ENABLE:  loop_r         = data[0];
            REG_BASE_WEIGHT:  base_weight_r  = data[15:0];
            REG_FADE_IN_LEN:  fade_in_len_r  = data[30:0];
            REG_FADE_OUT_LEN: fade_out_len_r = data[30:0];
            default: ;
        endcase
    endtask

    // Compare one status transfer with the oldest prediction
    task automatic check_status(input result_t got);
        result_t want;
        if (status_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: status with none predicted: playing %0d time %0d weight %0d",
                         $time, got.playing, got.play_time, got.weight);
        end
        else
        begin
            want = status_due.pop_front();
            if (got.playing !== want.playing || got.play_time !== want.play_time ||
                got.weight !== want.weight)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: status mismatch: playing %0d/%0d time %0d/%0d weight %0d/%0d",
                             $time, want.playing, got.playing, want.play_time,
                             got.play_time, want.weight, got.weight);
            end
        end
    endtask

    // Watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_r   = 31'd0;
            speed_r        = SPEED_RESET;
            anim_dur_r     = 31'd0;
            loop_r         = 1'b0;
            base_weight_r  = ONE_Q15;
            fade_in_len_r  = 31'd0;
            fade_out_len_r = 31'd0;
            time_now       = 32'd0;
            fade_in_left   = 32'd0;
            fade_out_left  = 32'd0;
            weight_now     = 16'd0;
            fading_out     = 1'b0;
            finished       = 1'b1;
            status_due.delete();
            fail_count     = 0;
            backlog       <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                store_register(cfg_index, cfg_data);
            if (result_valid && result_ready)
                check_status(result);
            if (item_valid && item_ready)
                predict_status(item);
            backlog <= status_due.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the playback clock fade envelope unit: stimulus, reset and verdict.
`timescale 1ns / 1ps

module tb_top
    import pcfe_pkg::*;
;

    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [30:0]          ONE_SEC    = 31'h0001_0000;
    localparam logic [30:0]          MAX_Q16    = 31'h7FFF_FFFF;
    localparam int RAND_ITEMS   = 900;
    localparam int CALM_ITEMS   = 120;
    localparam int DRAIN_CYCLES = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    backlog;

    logic        sender_bursts;
    logic        receiver_bursts;
    int          sent;
    logic [30:0] cur_span;

    playback_clock_fade_envelope_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    envelope_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .backlog      (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run well beyond the slowest correct one
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Stall the status channel in random bursts
    initial
    begin
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (receiver_bursts && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Hold valid until the item transfer; valid stays high for a following item
    task automatic send_item(input logic [1:0] opcode, input logic [30:0] delta);
        item_t pkt;
        pkt.opcode = opcode;
        pkt.delta  = delta;
        if (sender_bursts && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= pkt;
        do @(posedge clk); while (!item_ready);
        sent++;
    endtask

    // Stop sending and wait for every predicted status to arrive
    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (backlog != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write all registers, with junk in the bits above each register's width
    task automatic load_setting(input logic [30:0] st, input logic [15:0] spd,
                                input logic [30:0] dur, input logic lp,
                                input logic [15:0] bw, input logic [30:0] fin,
                                input logic [30:0] fout);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(REG_START_TIME, {junk[31], st});
        write_reg(REG_SPEED, {junk[31:16], spd});
        write_reg(REG_ANIM_DUR, {junk[30], dur});
        write_reg(REG_LOOP_ENABLE, {junk[31:1], lp});
        write_reg(REG_BASE_WEIGHT, {junk[15:0], bw});
        write_reg(REG_FADE_IN_LEN, {junk[29], fin});
        write_reg(REG_FADE_OUT_LEN, {junk[28], fout});
        cfg_valid <= 1'b0;
        cur_span = dur;
    endtask

    function automatic logic [30:0] pick_length();
        case ($urandom_range(0, 6))
            0: return 31'd0;
            1: return MAX_Q16;
            2: return 31'($urandom());
            default: return 31'($urandom_range(1, 32'h0008_0000));
        endcase
    endfunction

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom());
            default: return 16'($urandom_range(0, 768) - 256);
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return ONE_Q15;
            2: return 16'($urandom());
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [30:0] pick_delta(input logic [30:0] span);
        case ($urandom_range(0, 9))
            0: return 31'd0;
            1: return 31'($urandom());
            2, 3: return 31'($urandom_range(0, span >> 2));
            default: return 31'($urandom_range(0, 32'h0002_0000));
        endcase
    endfunction

    // One playback: start, a run of ticks, maybe a fade-out, a little noise
    task automatic play_sequence(input logic [30:0] span);
        int ticks;
        int fade_at;
        ticks   = $urandom_range(1, 20);
        fade_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ticks) : -1;
        send_item(OP_START, 31'($urandom()));
        for (int k = 0; k < ticks; k++)
        begin
            if (k == fade_at)
                send_item(OP_FADE, 31'($urandom()));
            if ($urandom_range(0, 19) == 0)
                send_item(2'($urandom()), 31'($urandom()));
            else
                send_item(OP_TICK, pick_delta(span));
        end
    endtask

    initial
    begin
        logic calm;
        rst_n           <= 1'b0;
        item_valid      <= 1'b0;
        item            <= '0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        sender_bursts    = 1'b0;
        receiver_bursts  = 1'b0;
        sent             = 0;
        cur_span         = 31'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: idle until start, unused opcode, fade arming while finished
        send_item(OP_TICK, MAX_Q16);
        send_item(OP_UNUSED, 31'd0);
        send_item(OP_FADE, 31'h5555_5555);
        send_item(OP_START, 31'd0);
        send_item(OP_TICK, 31'd1);
        drain_results();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);

        // Fade-in stopping at zero, fade-out reaching zero exactly, end at length
        load_setting(31'd0, SPEED_RESET, 31'(10 * ONE_SEC), 1'b0, ONE_Q15, ONE_SEC,
                     31'(2 * ONE_SEC));
        send_item(OP_START, 31'd0);
        send_item(OP_TICK, 31'h0000_4000);
        send_item(OP_TICK, ONE_SEC);
        send_item(OP_FADE, 31'd0);
        send_item(OP_TICK, 31'h0000_8000);
        send_item(OP_TICK, 31'h0001_8000);
        send_item(OP_TICK, MAX_Q16);
        send_item(OP_START, 31'd0);
        send_item(OP_FADE, 31'd0);
        send_item(OP_TICK, 31'h0002_0001);
        send_item(OP_START, 31'd0);
        send_item(OP_TICK, 31'd0);
        drain_results();

        // Loop wrap from above and from below, saturation, weight clamp
        load_setting(MAX_Q16, 16'h8000, 31'(3 * ONE_SEC), 1'b1, 16'hFFFF, MAX_Q16, 31'd0);
        send_item(OP_START, 31'd0);
        send_item(OP_TICK, 31'd0);
        send_item(OP_TICK, MAX_Q16);
        send_item(OP_FADE, 31'd0);
        send_item(OP_TICK, ONE_SEC);
        drain_results();

        // Zero length under loop forces position zero
        load_setting(31'(5 * ONE_SEC), 16'h7FFF, 31'd0, 1'b1, 16'd0, 31'd0, MAX_Q16);
        send_item(OP_START, 31'd0);
        send_item(OP_TICK, 31'h0000_1234);
        send_item(OP_FADE, 31'd0);
        send_item(OP_TICK, ONE_SEC);
        drain_results();

        // Negative position without loop keeps playing
        load_setting(31'd0, 16'hFF00, ONE_SEC, 1'b0, ONE_Q15, 31'd0, 31'd0);
        send_item(OP_START, 31'd0);
        send_item(OP_TICK, 31'h0000_8000);

        // Random settings, each followed by a few playbacks
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            drain_results();
            load_setting(($urandom_range(0, 2) == 0) ? 31'd0 : pick_length(), pick_speed(),
                         pick_length(), 1'($urandom()), pick_weight(), pick_length(),
                         pick_length());
            calm = (sent >= RAND_ITEMS - CALM_ITEMS);
            sender_bursts   = !calm && $urandom_range(0, 3) != 0;
            receiver_bursts = !calm && $urandom_range(0, 3) != 0;
            repeat ($urandom_range(3, 8)) play_sequence(cur_span);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
